/* hw/rtl/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants and types for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = 16;
    localparam int CELL_W = 11;
    localparam int STEP_W = 4;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [POS_W-1:0] POS_COLS  = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] POS_CELLS = POS_W'(CELLS);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(CELLS - 1);

    // character codes
    localparam logic [7:0] CHAR_NULL      = 8'h00;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // crtc cursor location registers
    localparam logic [7:0] CRTC_LOW_INDEX  = 8'h0F;
    localparam logic [7:0] CRTC_HIGH_INDEX = 8'h0E;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ON = 1'd1;

    // everything the emitter needs to produce the words of one character
    typedef struct packed {
        logic              has_cell;
        logic              cursor;
        logic              two_pos;
        logic [CELL_W-1:0] cell_index;
        logic [7:0]        glyph;
        logic [7:0]        attr;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
    } plan_t;

endpackage

/* hw/rtl/tccw_plan.sv */
// ----------------------------------------------------------------------------
// tccw_plan
// Cursor state and per-character decode into a registered emit plan.
// ----------------------------------------------------------------------------
module tccw_plan
    import tccw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic        cursor_on,
    input  logic        plan_take,
    output logic        plan_valid,
    output plan_t       plan
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             plan_valid_reg, plan_valid_next;
    plan_t            plan_reg, plan_next;
    logic             accept;
    logic             produces;
    logic [POS_W-1:0] base, pos, pos_inc, base_inc;
    logic [ROW_W-1:0] row_up;

    assign in_stall   = plan_valid_reg && !plan_take;
    assign accept     = in_valid && !in_stall;
    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

    // linear cursor position and its neighbors
    always_comb
    begin
        base     = POS_W'(row_reg) * POS_COLS;
        pos      = base + POS_W'(col_reg);
        pos_inc  = pos + POS_W'(1);
        base_inc = base + POS_COLS;
        row_up   = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
    end

    // decode one character
    always_comb
    begin
        col_next             = col_reg;
        row_next             = row_reg;
        plan_next            = '0;
        plan_next.cursor     = cursor_on;
        plan_next.attr       = attribute;
        case (char_code)
            CHAR_NEWLINE:
            begin
                col_next          = '0;
                row_next          = row_up;
                plan_next.two_pos = 1'b1;
                plan_next.pos_a   = base;
                plan_next.pos_b   = (base_inc == POS_CELLS) ? '0 : base_inc;
            end
            CHAR_RETURN:
            begin
                col_next        = '0;
                plan_next.pos_a = base;
            end
            CHAR_BACKSPACE:
            begin
                if (col_reg == '0)
                begin
                    col_next = COL_LAST;
                    row_next = (row_reg == '0) ? ROW_LAST : row_reg - ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg - COL_W'(1);
                end
                plan_next.has_cell   = 1'b1;
                plan_next.glyph      = CHAR_BLANK;
                plan_next.pos_a      = (pos == '0) ? POS_LAST : pos - POS_W'(1);
                plan_next.cell_index = plan_next.pos_a[CELL_W-1:0];
            end
            default:
            begin
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_up;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                plan_next.has_cell   = 1'b1;
                plan_next.glyph      = char_code;
                plan_next.cell_index = pos[CELL_W-1:0];
                plan_next.pos_a      = (pos_inc == POS_CELLS) ? '0 : pos_inc;
            end
        endcase
        produces = (char_code != CHAR_NULL) && (plan_next.has_cell || cursor_on);
    end

    // plan slot occupancy
    always_comb
    begin
        plan_valid_next = plan_valid_reg;
        if (plan_take)
            plan_valid_next = 1'b0;
        if (accept)
            plan_valid_next = produces;
    end

    // cursor state and plan slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            if (accept && (char_code != CHAR_NULL))
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // plan payload
    always_ff @(posedge clk)
    begin
        if (accept)
            plan_reg <= plan_next;
    end

endmodule

/* hw/rtl/tccw_emit.sv */
// ----------------------------------------------------------------------------
// tccw_emit
// Walks one plan word by word into the output register.
// ----------------------------------------------------------------------------
module tccw_emit
    import tccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              plan_valid,
    input  plan_t             plan,
    output logic              plan_take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [CELL_W-1:0] cell_index,
    output logic [7:0]        glyph,
    output logic [7:0]        cell_attribute,
    output logic [7:0]        port_byte,
    output logic              last
);

    // step numbering: cell write, then two groups of four port writes
    localparam logic [STEP_W-1:0] STEP_CELL   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_A_LIDX = 4'd1;
    localparam logic [STEP_W-1:0] STEP_A_LDAT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_A_HIDX = 4'd3;
    localparam logic [STEP_W-1:0] STEP_A_HDAT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_B_LIDX = 4'd5;
    localparam logic [STEP_W-1:0] STEP_B_LDAT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_B_HIDX = 4'd7;
    localparam logic [STEP_W-1:0] STEP_B_HDAT = 4'd8;

    logic              cur_valid_reg, cur_valid_next;
    plan_t             cur_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] end_step;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [7:0]        glyph_reg, glyph_next;
    logic [7:0]        attr_reg, attr_next;
    logic [7:0]        port_reg, port_next;
    logic              last_reg, last_next;
    logic              load_ok, emit, cur_done;

    assign end_step  = !cur_reg.cursor ? STEP_CELL :
                       (cur_reg.two_pos ? STEP_B_HDAT : STEP_A_HDAT);
    assign load_ok   = !out_valid_reg || !out_stall;
    assign emit      = cur_valid_reg && load_ok;
    assign cur_done  = emit && (step_reg == end_step);
    assign plan_take = plan_valid && (!cur_valid_reg || cur_done);

    // word for the current step
    always_comb
    begin
        kind_next  = KIND_DATA;
        cell_next  = '0;
        glyph_next = '0;
        attr_next  = '0;
        port_next  = '0;
        last_next  = (step_reg == end_step);
        case (step_reg)
            STEP_CELL:
            begin
                kind_next  = KIND_CELL;
                cell_next  = cur_reg.cell_index;
                glyph_next = cur_reg.glyph;
                attr_next  = cur_reg.attr;
            end
            STEP_A_LIDX:
            begin
                kind_next = KIND_INDEX;
                port_next = CRTC_LOW_INDEX;
            end
            STEP_A_LDAT: port_next = cur_reg.pos_a[7:0];
            STEP_A_HIDX:
            begin
                kind_next = KIND_INDEX;
                port_next = CRTC_HIGH_INDEX;
            end
            STEP_A_HDAT: port_next = cur_reg.pos_a[15:8];
            STEP_B_LIDX:
            begin
                kind_next = KIND_INDEX;
                port_next = CRTC_LOW_INDEX;
            end
            STEP_B_LDAT: port_next = cur_reg.pos_b[7:0];
            STEP_B_HIDX:
            begin
                kind_next = KIND_INDEX;
                port_next = CRTC_HIGH_INDEX;
            end
            STEP_B_HDAT: port_next = cur_reg.pos_b[15:8];
            default:     port_next = '0;
        endcase
    end

    // sequencer and output register control
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (!cur_valid_reg || cur_done)
        begin
            cur_valid_next = plan_valid;
            step_next      = plan.has_cell ? STEP_CELL : STEP_A_LIDX;
        end
        else if (emit)
        begin
            step_next = step_reg + STEP_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (load_ok)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_CELL;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (plan_take)
            cur_reg <= plan;
        if (emit)
        begin
            kind_reg  <= kind_next;
            cell_reg  <= cell_next;
            glyph_reg <= glyph_next;
            attr_reg  <= attr_next;
            port_reg  <= port_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign cell_index     = cell_reg;
    assign glyph          = glyph_reg;
    assign cell_attribute = attr_reg;
    assign port_byte      = port_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    // sequencer never runs past the end of its plan
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (step_reg <= end_step))
        else $error("emit step beyond plan end");

    // a finished plan with nothing queued leaves the sequencer empty
    a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_done && !plan_valid) |=> !cur_valid_reg)
        else $error("sequencer not emptied after last word");

    // index port words only carry cursor location register numbers
    a_index_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_INDEX) |->
        (port_reg == CRTC_LOW_INDEX || port_reg == CRTC_HIGH_INDEX))
        else $error("bad crtc index byte");

    // a character's final word is a cell write or a data port write
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |->
        (kind_reg == KIND_CELL || kind_reg == KIND_DATA))
        else $error("last flag on index port word");
`endif

endmodule

/* hw/rtl/text_console_char_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Character writer for an 80 x 25 text console with crtc cursor updates.
// ----------------------------------------------------------------------------
// Each accepted character code turns into zero to eight output words, one word
// per clock through the output register when not stalled. A printable code or
// backspace gives one cell write, plus four crtc port writes when the cursor is
// on. With the cursor on, carriage return gives four words and newline gives
// eight. Null gives none, and so do return and newline with the cursor off. The
// first word passes through the plan register and the sender's current plan
// register into the output register. One decoded character waits in the plan
// register behind the one being sent. A new character is taken in the cycle in
// which the one being sent puts out its last word, so the sender finishes one
// character before it starts the next. Single-word characters, like characters
// with no words, stream at one per cycle without stalls. An output stall holds
// the sender, and once the plan register is full it also stalls the input. The
// user must see that configuration is written while idle; no logic enforces it.
module text_console_char_writer_top
    import tccw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           char_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [CELL_W-1:0]    cell_index,
    output logic [7:0]           glyph,
    output logic [7:0]           cell_attribute,
    output logic [7:0]           port_byte,
    output logic                 last
);

    logic [7:0] attribute_reg;
    logic       cursor_on_reg;
    logic       plan_take;
    logic       plan_valid;
    plan_t      plan;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= 8'h0F;
            cursor_on_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTRIBUTE: attribute_reg <= cfg_data;
                REG_CURSOR_ON: cursor_on_reg <= cfg_data[0];
                default:       cursor_on_reg <= cursor_on_reg;
            endcase
        end
    end

    // decode and cursor tracking
    tccw_plan u_plan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .attribute  (attribute_reg),
        .cursor_on  (cursor_on_reg),
        .plan_take  (plan_take),
        .plan_valid (plan_valid),
        .plan       (plan)
    );

    // word sequencer and output register
    tccw_emit u_emit
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .plan_valid     (plan_valid),
        .plan           (plan),
        .plan_take      (plan_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .cell_index     (cell_index),
        .glyph          (glyph),
        .cell_attribute (cell_attribute),
        .port_byte      (port_byte),
        .last           (last)
    );

endmodule

/* verif/console_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_check_pkg
// Cursor tracker and word checker for the text console character writer.
// Each accepted character is played against a private copy of the cursor and
// the configuration, and the words it must cause are queued; every word that
// leaves the block is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
package console_check_pkg;

    import tccw_pkg::*;

    // one output word as it appears on the result ports
    typedef struct packed {
        logic [1:0]        kind;
        logic [CELL_W-1:0] cell_index;
        logic [7:0]        glyph;
        logic [7:0]        cell_attribute;
        logic [7:0]        port_byte;
        logic              last;
    } console_word_t;

    class console_screen_tracker;
        int            column;
        int            row;
        logic [7:0]    attribute;
        bit            cursor_on;
        console_word_t pending_words[$];
        int            errors;

        function new();
            column    = 0;
            row       = 0;
            attribute = 8'd15;
            cursor_on = 1'b0;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [7:0] data);
            case (index)
                REG_ATTRIBUTE: attribute = data;
                REG_CURSOR_ON: cursor_on = data[0];
                default: ;
            endcase
        endfunction

        function void push_word(logic [1:0] word_kind, int cell_num, logic [7:0] ch,
                                logic [7:0] attr, logic [7:0] port);
            console_word_t w;
            w.kind           = word_kind;
            w.cell_index     = CELL_W'(cell_num);
            w.glyph          = ch;
            w.cell_attribute = attr;
            w.port_byte      = port;
            w.last           = 1'b0;
            pending_words.push_back(w);
        endfunction

        // column overflow goes to the next row, row overflow back to the top
        function void wrap_cursor();
            if (column >= COLUMNS)
            begin
                column = 0;
                row++;
            end
            if (row >= ROWS)
                row = 0;
        endfunction

        // crtc cursor location: low byte under one index, high byte under the other
        function void push_cursor_update();
            logic [POS_W-1:0] pos;
            if (!cursor_on)
                return;
            pos = POS_W'(row * COLUMNS + column);
            push_word(KIND_INDEX, 0, 8'h00, 8'h00, CRTC_LOW_INDEX);
            push_word(KIND_DATA, 0, 8'h00, 8'h00, pos[7:0]);
            push_word(KIND_INDEX, 0, 8'h00, 8'h00, CRTC_HIGH_INDEX);
            push_word(KIND_DATA, 0, 8'h00, 8'h00, pos[15:8]);
        endfunction

        function void note_char(logic [7:0] code);
            int first;
            first = pending_words.size();
            case (code)
                CHAR_NULL:
                    return;
                CHAR_NEWLINE:
                begin
                    // carriage return with its own cursor update, then next row
                    column = 0;
                    wrap_cursor();
                    push_cursor_update();
                    row++;
                end
                CHAR_RETURN:
                    column = 0;
                CHAR_BACKSPACE:
                begin
                    if (column == 0)
                    begin
                        column = COLUMNS - 1;
                        row    = (row == 0) ? ROWS - 1 : row - 1;
                    end
                    else
                        column--;
                    push_word(KIND_CELL, row * COLUMNS + column, CHAR_BLANK, attribute, 8'h00);
                end
                default:
                begin
                    push_word(KIND_CELL, row * COLUMNS + column, code, attribute, 8'h00);
                    column++;
                end
            endcase
            wrap_cursor();
            push_cursor_update();
            if (pending_words.size() > first)
                pending_words[pending_words.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
            if (actual !== expected)
            begin
                $error("%s: expected %0d, got %0d", name, expected, actual);
                errors++;
            end
        endfunction

        function void check_word(console_word_t got);
            console_word_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: kind %0d cell_index %0d port_byte %0d",
                       got.kind, got.cell_index, got.port_byte);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("cell_index", 16'(want.cell_index), 16'(got.cell_index));
            compare_field("glyph", 16'(want.glyph), 16'(got.glyph));
            compare_field("cell_attribute", 16'(want.cell_attribute), 16'(got.cell_attribute));
            compare_field("port_byte", 16'(want.port_byte), 16'(got.port_byte));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the text console character writer.
// A directed opening covers the cursor wraps at the screen corners, every
// control code and the byte extremes, then random phases with changing
// attribute and cursor settings follow. Both handshakes idle at random, and
// once the output is held off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_top;

    import tccw_pkg::*;
    import console_check_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_CHARS   = 50;

    localparam logic [7:0] OPENING_CODES [13] = '{
        CHAR_RETURN, CHAR_BACKSPACE, CHAR_NEWLINE, 8'hFF, CHAR_NULL, 8'h01,
        CHAR_BACKSPACE, CHAR_BACKSPACE, 8'h80, 8'h7F, 8'h55, 8'hAA, CHAR_NEWLINE
    };

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [7:0]           cfg_data       = 8'h00;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [7:0]           char_code      = 8'h00;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [1:0]           kind;
    logic [CELL_W-1:0]    cell_index;
    logic [7:0]           glyph;
    logic [7:0]           cell_attribute;
    logic [7:0]           port_byte;
    logic                 last;

    console_screen_tracker screen;
    int                    hold_cycles = 0;

    text_console_char_writer_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .cell_index     (cell_index),
        .glyph          (glyph),
        .cell_attribute (cell_attribute),
        .port_byte      (port_byte),
        .last           (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_code(int newline_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < newline_pct)
            return CHAR_NEWLINE;
        if (r < newline_pct + 5)
            return CHAR_RETURN;
        if (r < newline_pct + 15)
            return CHAR_BACKSPACE;
        if (r < newline_pct + 18)
            return CHAR_NULL;
        return 8'($urandom_range(0, 255));
    endfunction

    // one character word, then an optional pause with valid low
    task automatic send_char(input logic [7:0] code, input int gap);
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        screen.note_char(code);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // input quiet, all words back, then room for a word-less character in flight
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (screen.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        screen.write_register(index, data);
    endtask

    task automatic set_cursor(input bit on);
        logic [7:0] data;
        data    = 8'($urandom_range(0, 255));
        data[0] = on;
        write_register(REG_CURSOR_ON, data);
    endtask

    // output stall: stretches of no stall, random stall, or solid stall
    initial
    begin : receiver_pacing
        int stretch_left;
        int stall_pct;
        stretch_left = 0;
        stall_pct    = 0;
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(10, 60);
                case ($urandom_range(0, 9))
                    0, 1, 2: stall_pct = 0;
                    3:
                    begin
                        stall_pct    = 100;
                        stretch_left = $urandom_range(15, 40);
                    end
                    default: stall_pct = $urandom_range(10, 40);
                endcase
            end
            stretch_left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    // output monitor
    initial
    begin : word_monitor
        console_word_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.kind           = kind;
                got.cell_index     = cell_index;
                got.glyph          = glyph;
                got.cell_attribute = cell_attribute;
                got.port_byte      = port_byte;
                got.last           = last;
                screen.check_word(got);
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int         sent;
        int         newline_pct;
        int         gap;
        logic [7:0] code;
        logic [7:0] attr;

        screen = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: backspace at the top-left corner, then a write in the
        // bottom-right cell that overflows both column and row
        send_char(CHAR_BACKSPACE, pick_gap());
        send_char(8'h41, pick_gap());
        send_char(8'h7E, pick_gap());
        wait_idle();

        // cursor on, brightest attribute, all control codes and byte extremes
        write_register(REG_ATTRIBUTE, 8'hFF);
        set_cursor(1'b1);
        foreach (OPENING_CODES[i])
            send_char(OPENING_CODES[i], pick_gap());
        wait_idle();

        write_register(REG_ATTRIBUTE, 8'h00);
        set_cursor(1'b0);
        send_char(8'h20, pick_gap());
        send_char(CHAR_NEWLINE, pick_gap());
        send_char(8'h09, pick_gap());
        wait_idle();

        // random phases, each with its own settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: attr = 8'h00;
                1: attr = 8'hFF;
                default: attr = 8'($urandom_range(0, 255));
            endcase
            write_register(REG_ATTRIBUTE, attr);
            case (phase)
                0: set_cursor(1'b1);
                1: set_cursor(1'b0);
                default: set_cursor(1'($urandom_range(0, 1)));
            endcase
            case ($urandom_range(0, 2))
                0: newline_pct = 2;
                1: newline_pct = 10;
                default: newline_pct = 25;
            endcase

            sent = 0;
            while (sent < PHASE_CHARS)
            begin
                // long output hold-off while characters keep coming
                if (phase == 3 && sent == 10)
                    hold_cycles = 300;
                if ((phase == 3 && sent >= 10 && sent < 50) || phase == 5)
                    gap = 0;
                else
                    gap = pick_gap();
                code = pick_code(newline_pct);
                send_char(code, gap);
                if (code != CHAR_NULL)
                    sent++;
            end
            wait_idle();
        end

        if (screen.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
